// ----- hdl/ssr_pkg.sv -----
// ----------------------------------------------------------------------------
// ssr_pkg
// shared types, codes and constants of the single spin rotation engine
// ----------------------------------------------------------------------------
`default_nettype none

package ssr_pkg;

    localparam int MAX_SPINS_DEFAULT = 10;

    // port widths
    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register reset values
    localparam logic [3:0]         NUM_SPINS_RESET = 4'd10;
    localparam logic signed [15:0] COS_HALF_RESET  = 16'sh7FFF;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_ROTATE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_SPIN  = 2'd1,
        STAT_BAD_INDEX = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NUM_SPINS = 3'd0,
        CFG_COS_HALF  = 3'd1,
        CFG_SIN_NX    = 3'd2,
        CFG_SIN_NY    = 3'd3,
        CFG_SIN_NZ    = 3'd4
    } cfg_idx_t;

    // one complex amplitude, q1.15 parts
    typedef struct packed {
        logic signed [15:0] im_val;
        logic signed [15:0] re_val;
    } amp_t;

    // rotation matrix terms
    typedef struct packed {
        logic signed [15:0] c;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } coef_t;

    typedef struct packed {
        op_t                op;
        logic [9:0]         index;
        logic signed [15:0] wr_real;
        logic signed [15:0] wr_imag;
        logic [3:0]         target_spin;
    } item_t;

    typedef struct packed {
        status_t status;
        amp_t    amp;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/ssr_bank.sv -----
// ----------------------------------------------------------------------------
// ssr_bank
// amplitude bank: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_bank #(
    parameter int ADDR_W = ssr_pkg::MAX_SPINS_DEFAULT - 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  ssr_pkg::amp_t     wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output ssr_pkg::amp_t     rdata
);
    import ssr_pkg::*;

    amp_t store_mem [2**ADDR_W];
    amp_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hdl/ssr_butterfly.sv -----
// ----------------------------------------------------------------------------
// ssr_butterfly
// 2x2 complex rotation of one amplitude pair, two register stages
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_butterfly (
    input  logic           aclk,
    input  ssr_pkg::coef_t coef,
    input  ssr_pkg::amp_t  a,
    input  ssr_pkg::amp_t  b,
    output ssr_pkg::amp_t  lo,
    output ssr_pkg::amp_t  hi
);
    import ssr_pkg::*;

    function automatic logic signed [33:0] sx(input logic signed [31:0] p);
        return {{2{p[31]}}, p};
    endfunction

    // round to nearest (ties up) from q2.30 to q1.15, then saturate
    function automatic logic signed [15:0] round_sat(input logic signed [33:0] s);
        logic signed [33:0] t;
        logic signed [33:0] q;
        t = s + 34'sd16384;
        q = t >>> 15;
        if (q > 34'sd32767) begin
            return 16'sh7FFF;
        end else if (q < -34'sd32768) begin
            return 16'sh8000;
        end else begin
            return q[15:0];
        end
    endfunction

    // stage 1: all sixteen products
    logic signed [31:0] c_ar_reg, c_ai_reg, c_br_reg, c_bi_reg;
    logic signed [31:0] x_ar_reg, x_ai_reg, x_br_reg, x_bi_reg;
    logic signed [31:0] y_ar_reg, y_ai_reg, y_br_reg, y_bi_reg;
    logic signed [31:0] z_ar_reg, z_ai_reg, z_br_reg, z_bi_reg;

    // stage 2: rounded sums
    amp_t lo_reg;
    amp_t hi_reg;

    always_ff @(posedge aclk) begin
        c_ar_reg <= coef.c * a.re_val;
        c_ai_reg <= coef.c * a.im_val;
        c_br_reg <= coef.c * b.re_val;
        c_bi_reg <= coef.c * b.im_val;
        x_ar_reg <= coef.x * a.re_val;
        x_ai_reg <= coef.x * a.im_val;
        x_br_reg <= coef.x * b.re_val;
        x_bi_reg <= coef.x * b.im_val;
        y_ar_reg <= coef.y * a.re_val;
        y_ai_reg <= coef.y * a.im_val;
        y_br_reg <= coef.y * b.re_val;
        y_bi_reg <= coef.y * b.im_val;
        z_ar_reg <= coef.z * a.re_val;
        z_ai_reg <= coef.z * a.im_val;
        z_br_reg <= coef.z * b.re_val;
        z_bi_reg <= coef.z * b.im_val;
    end

    always_ff @(posedge aclk) begin
        lo_reg.re_val <= round_sat(sx(c_ar_reg) - sx(z_ai_reg) + sx(y_br_reg) + sx(x_bi_reg));
        lo_reg.im_val <= round_sat(sx(c_ai_reg) + sx(z_ar_reg) + sx(y_bi_reg) - sx(x_br_reg));
        hi_reg.re_val <= round_sat(sx(x_ai_reg) - sx(y_ar_reg) + sx(c_br_reg) + sx(z_bi_reg));
        hi_reg.im_val <= round_sat(sx(c_bi_reg) - sx(y_ai_reg) - sx(x_ar_reg) - sx(z_br_reg));
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

`default_nettype wire

// ----- hdl/ssr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssr_ctrl
// sequencer: clearing pass, item decode, pair walk and bank port control
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_ctrl #(
    parameter int  MAX_SPINS = ssr_pkg::MAX_SPINS_DEFAULT,
    localparam int BAW       = (MAX_SPINS > 1) ? MAX_SPINS - 1 : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    // item side
    input  logic             in_valid,
    output logic             in_ready,
    input  ssr_pkg::item_t   in_item,
    input  logic [3:0]       num_spins,
    // result side
    output logic             res_valid,
    input  logic             res_ready,
    output ssr_pkg::result_t res,
    // bank 0
    output logic             b0_we,
    output logic [BAW-1:0]   b0_waddr,
    output ssr_pkg::amp_t    b0_wdata,
    output logic             b0_re,
    output logic [BAW-1:0]   b0_raddr,
    input  ssr_pkg::amp_t    b0_rdata,
    // bank 1
    output logic             b1_we,
    output logic [BAW-1:0]   b1_waddr,
    output ssr_pkg::amp_t    b1_wdata,
    output logic             b1_re,
    output logic [BAW-1:0]   b1_raddr,
    input  ssr_pkg::amp_t    b1_rdata,
    // butterfly
    output ssr_pkg::amp_t    bf_a,
    output ssr_pkg::amp_t    bf_b,
    input  ssr_pkg::amp_t    bf_lo,
    input  ssr_pkg::amp_t    bf_hi
);
    import ssr_pkg::*;

    localparam int AW = MAX_SPINS;
    localparam int CW = $clog2(MAX_SPINS + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ROT,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // bank select is the parity of the index, so the two members of a pair
    // always sit in different banks
    typedef struct packed {
        logic           swap;
        logic [BAW-1:0] a0;
        logic [BAW-1:0] a1;
    } tag_t;

    function automatic logic [BAW-1:0] bank_addr(input logic [AW-1:0] idx_in);
        logic [AW:0] ext;
        ext = {1'b0, idx_in};
        return BAW'(ext >> 1);
    endfunction

    state_t         state_reg, state_next;
    logic [BAW-1:0] clr_reg, clr_next;
    logic [AW-1:0]  pair_reg, pair_next;
    logic [3:0]     spin_reg, spin_next;
    logic           rd_sel_reg, rd_sel_next;
    result_t        res_reg, res_next;
    logic           v1_reg, v2_reg, v3_reg;
    tag_t           tag1_reg, tag2_reg, tag3_reg;

    logic [CW-1:0]  eff;
    logic [CW-1:0]  eff_m1;
    logic           idx_ok;
    logic           spin_ok;
    logic [AW-1:0]  idx;
    logic           idx_par;
    logic           accept;
    logic           rd_issue;
    logic           wr_issue;
    logic           issue;
    logic [AW-1:0]  stride;
    logic [AW-1:0]  low_mask;
    logic [AW-1:0]  lo_idx;
    logic [AW-1:0]  hi_idx;
    tag_t           issue_tag;
    logic [AW-1:0]  pair_inc;
    logic           last_pair;
    amp_t           wr_amp;

    // spins in use, saturated into one to MAX_SPINS
    always_comb begin
        if (num_spins == '0) begin
            eff = CW'(1);
        end else if (int'(num_spins) > MAX_SPINS) begin
            eff = CW'(MAX_SPINS);
        end else begin
            eff = CW'(num_spins);
        end
    end

    assign eff_m1  = eff - CW'(1);
    assign idx_ok  = (in_item.index >> eff) == '0;
    assign spin_ok = int'(in_item.target_spin) < int'(eff);
    assign idx     = AW'(in_item.index);
    assign idx_par = ^idx;

    assign accept   = in_valid && in_ready;
    assign rd_issue = accept && (in_item.op == OP_READ) && idx_ok;
    assign wr_issue = accept && (in_item.op == OP_WRITE) && idx_ok;
    assign issue    = (state_reg == ST_ROT);

    // pair number to index pair: open a zero bit at the target spin
    assign stride    = AW'(1) << spin_reg;
    assign low_mask  = stride - AW'(1);
    assign lo_idx    = ((pair_reg & ~low_mask) << 1) | (pair_reg & low_mask);
    assign hi_idx    = lo_idx | stride;
    assign pair_inc  = pair_reg + AW'(1);
    assign last_pair = (pair_inc >> eff_m1) != '0;

    always_comb begin
        issue_tag.swap = ^lo_idx;
        issue_tag.a0   = issue_tag.swap ? bank_addr(hi_idx) : bank_addr(lo_idx);
        issue_tag.a1   = issue_tag.swap ? bank_addr(lo_idx) : bank_addr(hi_idx);
    end

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        pair_next   = pair_reg;
        spin_next   = spin_reg;
        rd_sel_next = rd_sel_reg;
        res_next    = res_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + BAW'(1);
                if (&clr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    res_next.amp    = '0;
                    res_next.status = STAT_OK;
                    unique case (in_item.op)
                        OP_WRITE: begin
                            if (!idx_ok) begin
                                res_next.status = STAT_BAD_INDEX;
                            end
                            state_next = ST_DONE;
                        end
                        OP_READ: begin
                            if (!idx_ok) begin
                                res_next.status = STAT_BAD_INDEX;
                                state_next      = ST_DONE;
                            end else begin
                                rd_sel_next = idx_par;
                                state_next  = ST_READ;
                            end
                        end
                        OP_ROTATE: begin
                            if (!spin_ok) begin
                                res_next.status = STAT_BAD_SPIN;
                                state_next      = ST_DONE;
                            end else begin
                                spin_next  = in_item.target_spin;
                                pair_next  = '0;
                                state_next = ST_ROT;
                            end
                        end
                        OP_NONE: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_next.amp = rd_sel_reg ? b1_rdata : b0_rdata;
                state_next   = ST_DONE;
            end
            ST_ROT: begin
                pair_next = pair_inc;
                if (last_pair) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!(v1_reg || v2_reg || v3_reg)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            pair_reg   <= '0;
            spin_reg   <= '0;
            rd_sel_reg <= 1'b0;
            res_reg    <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            pair_reg   <= pair_next;
            spin_reg   <= spin_next;
            rd_sel_reg <= rd_sel_next;
            res_reg    <= res_next;
            v1_reg     <= issue;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
        end
    end

    // pair addresses travel beside the butterfly
    always_ff @(posedge aclk) begin
        tag1_reg <= issue_tag;
        tag2_reg <= tag1_reg;
        tag3_reg <= tag2_reg;
    end

    assign bf_a = tag1_reg.swap ? b1_rdata : b0_rdata;
    assign bf_b = tag1_reg.swap ? b0_rdata : b1_rdata;

    assign wr_amp = '{im_val: in_item.wr_imag, re_val: in_item.wr_real};

    // write ports: clearing pass, then rotation write-back, then item writes
    always_comb begin
        b0_we    = 1'b0;
        b1_we    = 1'b0;
        b0_waddr = tag3_reg.a0;
        b1_waddr = tag3_reg.a1;
        b0_wdata = tag3_reg.swap ? bf_hi : bf_lo;
        b1_wdata = tag3_reg.swap ? bf_lo : bf_hi;
        priority if (state_reg == ST_CLEAR) begin
            b0_we    = 1'b1;
            b1_we    = 1'b1;
            b0_waddr = clr_reg;
            b1_waddr = clr_reg;
            b0_wdata = '0;
            b1_wdata = '0;
        end else if (v3_reg) begin
            b0_we = 1'b1;
            b1_we = 1'b1;
        end else if (wr_issue) begin
            b0_we    = !idx_par;
            b1_we    = idx_par;
            b0_waddr = bank_addr(idx);
            b1_waddr = bank_addr(idx);
            b0_wdata = wr_amp;
            b1_wdata = wr_amp;
        end
    end

    assign b0_re    = issue || (rd_issue && !idx_par);
    assign b1_re    = issue || (rd_issue && idx_par);
    assign b0_raddr = issue ? issue_tag.a0 : bank_addr(idx);
    assign b1_raddr = issue ? issue_tag.a1 : bank_addr(idx);

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // pipeline has drained whenever an item may enter or a result waits
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> !(v1_reg || v2_reg || v3_reg))
        else $error("rotation pipeline busy outside a rotation");

    a_pair_banks: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> ((^lo_idx) != (^hi_idx)))
        else $error("pair members mapped to the same bank");

    a_read_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_issue |=> (state_reg == ST_READ))
        else $error("read issued without a data capture cycle");

    a_no_wr_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> !wr_issue)
        else $error("item write collides with rotation write-back");

endmodule

`default_nettype wire

// ----- hdl/single_spin_rotation_engine_unit.sv -----
// ----------------------------------------------------------------------------
// single_spin_rotation_engine_unit
// state vector store with write, read and single spin rotation items
// ----------------------------------------------------------------------------
//
// channel  dir  handshake          contents
// s_       in   s_tvalid/s_tready  item: op in tuser, index/values/spin in tdata
// m_       out  m_tvalid/m_tready  result: status in tuser, read value in tdata
// cfg_     in   cfg_valid/ready    register write: index and data
//
// write, op 3 and any rejected item: result leaves through ST_DONE and the output register
// read: bank data captured in ST_READ, then ST_DONE and the output register
// rotation: one amplitude pair per cycle, set by the single write port of each
//   of the two banks
// after reset both banks are cleared side by side over every address and no item
//   is taken until that is over
// one item at a time; the next item is taken while a result waits in the
//   output register, its own result then waits until that register frees
//
`default_nettype none

module single_spin_rotation_engine_unit #(
    parameter int MAX_SPINS = ssr_pkg::MAX_SPINS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // item input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [9:0] index, [25:10] wr_real, [41:26] wr_imag, [45:42] target_spin, rest zero
    input  logic [ssr_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] op
    input  logic [ssr_pkg::S_TUSER_W-1:0]    s_tuser,
    // result output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] rd_real, [31:16] rd_imag
    output logic [ssr_pkg::M_TDATA_W-1:0]    m_tdata,
    // [1:0] status
    output logic [ssr_pkg::M_TUSER_W-1:0]    m_tuser,
    // register writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ssr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ssr_pkg::*;

    localparam int BAW = (MAX_SPINS > 1) ? MAX_SPINS - 1 : 1;

    // configuration registers
    logic [3:0] num_spins_reg;
    coef_t      coef_reg;

    // output register
    logic       m_valid_reg;
    result_t    m_res_reg;

    item_t      item;
    logic       res_valid;
    logic       res_ready;
    result_t    res;

    // bank wiring
    logic       b0_we, b1_we, b0_re, b1_re;
    logic [BAW-1:0] b0_waddr, b1_waddr, b0_raddr, b1_raddr;
    amp_t       b0_wdata, b1_wdata, b0_rdata, b1_rdata;

    // butterfly wiring
    amp_t       bf_a, bf_b, bf_lo, bf_hi;

    // registers take a write in any cycle, only idle writes are meaningful
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_spins_reg <= NUM_SPINS_RESET;
            coef_reg.c    <= COS_HALF_RESET;
            coef_reg.x    <= '0;
            coef_reg.y    <= '0;
            coef_reg.z    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NUM_SPINS: num_spins_reg <= cfg_data[3:0];
                CFG_COS_HALF:  coef_reg.c    <= cfg_data;
                CFG_SIN_NX:    coef_reg.x    <= cfg_data;
                CFG_SIN_NY:    coef_reg.y    <= cfg_data;
                CFG_SIN_NZ:    coef_reg.z    <= cfg_data;
                default: begin
                    // writes past the register list are dropped
                end
            endcase
        end
    end

    // unpack the item transfer
    always_comb begin
        item.op          = op_t'(s_tuser[1:0]);
        item.index       = s_tdata[9:0];
        item.wr_real     = s_tdata[25:10];
        item.wr_imag     = s_tdata[41:26];
        item.target_spin = s_tdata[45:42];
    end

    ssr_ctrl #(
        .MAX_SPINS (MAX_SPINS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .num_spins (num_spins_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .b0_we     (b0_we),
        .b0_waddr  (b0_waddr),
        .b0_wdata  (b0_wdata),
        .b0_re     (b0_re),
        .b0_raddr  (b0_raddr),
        .b0_rdata  (b0_rdata),
        .b1_we     (b1_we),
        .b1_waddr  (b1_waddr),
        .b1_wdata  (b1_wdata),
        .b1_re     (b1_re),
        .b1_raddr  (b1_raddr),
        .b1_rdata  (b1_rdata),
        .bf_a      (bf_a),
        .bf_b      (bf_b),
        .bf_lo     (bf_lo),
        .bf_hi     (bf_hi)
    );

    // even-parity indices
    ssr_bank #(
        .ADDR_W (BAW)
    ) u_bank0 (
        .aclk  (aclk),
        .we    (b0_we),
        .waddr (b0_waddr),
        .wdata (b0_wdata),
        .re    (b0_re),
        .raddr (b0_raddr),
        .rdata (b0_rdata)
    );

    // odd-parity indices
    ssr_bank #(
        .ADDR_W (BAW)
    ) u_bank1 (
        .aclk  (aclk),
        .we    (b1_we),
        .waddr (b1_waddr),
        .wdata (b1_wdata),
        .re    (b1_re),
        .raddr (b1_raddr),
        .rdata (b1_rdata)
    );

    ssr_butterfly u_butterfly (
        .aclk (aclk),
        .coef (coef_reg),
        .a    (bf_a),
        .b    (bf_b),
        .lo   (bf_lo),
        .hi   (bf_hi)
    );

    // output register: loads when empty or being emptied by this transfer
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.amp.im_val, m_res_reg.amp.re_val};
    assign m_tuser  = m_res_reg.status;

endmodule

`default_nettype wire
